[sv/point_in_convex_polygon_assert.svh]
// ----------------------------------------------------------------------------
// Point-in-convex-polygon assertion macros
// Shorthand for clocked port checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_CONVEX_POLYGON_ASSERT_SVH
`define POINT_IN_CONVEX_POLYGON_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PCP_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PCP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pcp_pkg.sv]
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared types, widths, codes and the per-edge step schedule.
// ----------------------------------------------------------------------------
package pcp_pkg;

  // Field widths
  localparam int COORD_W    = 24;   // Q12.12 coordinate
  localparam int NORM_W     = 16;   // Q1.15 normal component
  localparam int CNT_W      = 5;    // vertex_count register
  localparam int VIDX_W     = 4;    // vertex_index field
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int VTX_W      = 3 * COORD_W;

  // Datapath widths, exact for all inputs
  localparam int DIFF_W  = COORD_W + 1;   // edge vector, shifted point
  localparam int B_W     = COORD_W + 2;   // point minus edge start
  localparam int MUL_W   = 27;            // shared multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CROSS_W = 52;            // cross product component
  localparam int HALF_W  = CROSS_W / 2;   // split of a cross component
  localparam int DOT_W   = 70;            // triple product

  localparam int DEFAULT_MAX_VERTICES = 16;
  localparam int MIN_VERTICES         = 3;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = 3'd6;

  localparam logic [CNT_W-1:0]  RST_VERTEX_COUNT = 5'd3;
  localparam logic [NORM_W-1:0] RST_NORMAL_Z     = 16'h7FFF;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_FIRST,
    S_LD_FIRST,
    S_RD_NEXT,
    S_SETUP,
    S_MAC,
    S_ADV,
    S_FIN
  } state_t;

  // Multiplier operand selects
  typedef enum logic [2:0] {
    OPA_AX,
    OPA_AY,
    OPA_AZ,
    OPA_CLO,
    OPA_CHI
  } opa_t;

  typedef enum logic [2:0] {
    OPB_BX,
    OPB_BY,
    OPB_BZ,
    OPB_NX,
    OPB_NY,
    OPB_NZ
  } opb_t;

  // What to do with the product in the cycle after it is issued
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CROSS_LOAD,
    ACT_CROSS_DIFF,
    ACT_DOT_LOAD,
    ACT_DOT_LO,
    ACT_DOT_HI,
    ACT_DOT_HI_LAST
  } act_t;

  typedef struct packed {
    opa_t opa;
    opb_t opb;
    act_t act;
  } mac_ctrl_t;

  typedef struct packed {
    logic done;   // triple product complete this cycle
    logic neg;    // its sign
  } mac_stat_t;

  typedef struct packed {
    logic take_point;
    logic mem_rd;
    logic take_first;
    logic take_edge;
    logic advance;
  } seq_ctrl_t;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] MAC_LAST_STEP = 4'd13;

  // Per-edge schedule: cx, cy, cz each take two products, and each is
  // folded into the dot sum as a low and a high half times the normal.
  function automatic mac_ctrl_t mac_step(input logic [STEP_W-1:0] step);
    mac_ctrl_t c;
    c = '{opa: OPA_AX, opb: OPB_BX, act: ACT_NONE};
    case (step)
      4'd0:  c = '{opa: OPA_AY,  opb: OPB_BZ, act: ACT_CROSS_LOAD};
      4'd1:  c = '{opa: OPA_AZ,  opb: OPB_BY, act: ACT_CROSS_DIFF};
      4'd2:  c = '{opa: OPA_AZ,  opb: OPB_BX, act: ACT_CROSS_LOAD};
      4'd3:  c = '{opa: OPA_CLO, opb: OPB_NX, act: ACT_DOT_LOAD};
      4'd4:  c = '{opa: OPA_CHI, opb: OPB_NX, act: ACT_DOT_HI};
      4'd5:  c = '{opa: OPA_AX,  opb: OPB_BZ, act: ACT_CROSS_DIFF};
      4'd6:  c = '{opa: OPA_AX,  opb: OPB_BY, act: ACT_CROSS_LOAD};
      4'd7:  c = '{opa: OPA_CLO, opb: OPB_NY, act: ACT_DOT_LO};
      4'd8:  c = '{opa: OPA_CHI, opb: OPB_NY, act: ACT_DOT_HI};
      4'd9:  c = '{opa: OPA_AY,  opb: OPB_BX, act: ACT_CROSS_DIFF};
      4'd11: c = '{opa: OPA_CLO, opb: OPB_NZ, act: ACT_DOT_LO};
      4'd12: c = '{opa: OPA_CHI, opb: OPB_NZ, act: ACT_DOT_HI_LAST};
      default: c = '{opa: OPA_AX, opb: OPB_BX, act: ACT_NONE};
    endcase
    return c;
  endfunction

endpackage

[sv/pcp_vmem.sv]
// ----------------------------------------------------------------------------
// pcp_vmem
// Vertex table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcp_vmem
  import pcp_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_VERTICES
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [VTX_W-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [VTX_W-1:0]         rd_data
);

  logic [VTX_W-1:0] mem [DEPTH];

  // Write a vertex
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read a vertex; the read data is registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/pcp_mac.sv]
// ----------------------------------------------------------------------------
// pcp_mac
// Shared 27x27 signed multiplier with cross and triple-product accumulators.
// ----------------------------------------------------------------------------
module pcp_mac
  import pcp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctrl_t                ctrl,
  input  logic signed [DIFF_W-1:0] ax,
  input  logic signed [DIFF_W-1:0] ay,
  input  logic signed [DIFF_W-1:0] az,
  input  logic signed [B_W-1:0]    bx,
  input  logic signed [B_W-1:0]    by,
  input  logic signed [B_W-1:0]    bz,
  input  logic signed [NORM_W-1:0] nx,
  input  logic signed [NORM_W-1:0] ny,
  input  logic signed [NORM_W-1:0] nz,
  output mac_stat_t                stat
);

  logic signed [MUL_W-1:0]   op_a;
  logic signed [MUL_W-1:0]   op_b;
  logic signed [PROD_W-1:0]  prod;
  act_t                      act_q;
  logic signed [CROSS_W-1:0] cross_acc;
  logic signed [CROSS_W-1:0] c_hold;
  logic signed [DOT_W-1:0]   dot;
  logic signed [DOT_W-1:0]   dot_next;
  logic signed [DOT_W-1:0]   lo_term;
  logic signed [DOT_W-1:0]   hi_term;

  // Select multiplier operands
  always_comb begin
    case (ctrl.opa)
      OPA_AX:  op_a = MUL_W'(ax);
      OPA_AY:  op_a = MUL_W'(ay);
      OPA_AZ:  op_a = MUL_W'(az);
      OPA_CLO: op_a = $signed({1'b0, c_hold[HALF_W-1:0]});
      OPA_CHI: op_a = MUL_W'($signed(c_hold[CROSS_W-1:HALF_W]));
      default: op_a = '0;
    endcase
    case (ctrl.opb)
      OPB_BX:  op_b = MUL_W'(bx);
      OPB_BY:  op_b = MUL_W'(by);
      OPB_BZ:  op_b = MUL_W'(bz);
      OPB_NX:  op_b = MUL_W'(nx);
      OPB_NY:  op_b = MUL_W'(ny);
      OPB_NZ:  op_b = MUL_W'(nz);
      default: op_b = '0;
    endcase
  end

  // Register the product and the action that goes with it
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (rst) begin
      act_q <= ACT_NONE;
    end else begin
      act_q <= ctrl.act;
    end
  end

  // Line up a half product at its weight in the triple product
  assign lo_term = DOT_W'(prod);
  assign hi_term = DOT_W'(prod) <<< HALF_W;

  always_comb begin
    case (act_q)
      ACT_DOT_LOAD:    dot_next = lo_term;
      ACT_DOT_LO:      dot_next = dot + lo_term;
      ACT_DOT_HI:      dot_next = dot + hi_term;
      ACT_DOT_HI_LAST: dot_next = dot + hi_term;
      default:         dot_next = dot;
    endcase
  end

  // Accumulate cross components and the triple product
  always_ff @(posedge clk) begin
    case (act_q)
      ACT_CROSS_LOAD: cross_acc <= CROSS_W'(prod);
      ACT_CROSS_DIFF: c_hold    <= cross_acc - CROSS_W'(prod);
      default: ;
    endcase
    dot <= dot_next;
  end

  assign stat.done = (act_q == ACT_DOT_HI_LAST);
  assign stat.neg  = dot_next[DOT_W-1];

endmodule

[sv/pcp_seq.sv]
// ----------------------------------------------------------------------------
// pcp_seq
// Query sequencer: walks the edges, steps the shared multiplier, holds the
// result register.
// ----------------------------------------------------------------------------
module pcp_seq
  import pcp_pkg::*;
#(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            req_type,
  input  logic                            out_stall,
  input  logic [CNT_W-1:0]                vertex_count,
  input  mac_stat_t                       mac_stat,
  output logic                            in_stall,
  output logic                            out_valid,
  output logic                            inside_res,
  output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
  output seq_ctrl_t                       ctrl,
  output mac_ctrl_t                       mac_ctrl
);

  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int NW0 = $clog2(MAX_VERTICES + 1);
  localparam int LW  = (NW0 > CNT_W) ? NW0 : CNT_W;

  state_t            state;
  state_t            state_next;
  logic [IW-1:0]     edge_idx;
  logic [IW-1:0]     last_idx;
  logic [IW-1:0]     next_idx;
  logic [STEP_W-1:0] step;
  logic              all_neg;
  logic              query_go;
  logic              res_free;
  logic              out_valid_next;
  logic [LW-1:0]     vc_ext;
  logic [LW-1:0]     n_eff;
  logic [LW-1:0]     n_m1;

  // Clamp the vertex count into the supported range
  always_comb begin
    vc_ext = LW'(vertex_count);
    if (vc_ext < LW'(MIN_VERTICES)) begin
      n_eff = LW'(MIN_VERTICES);
    end else if (vc_ext > LW'(MAX_VERTICES)) begin
      n_eff = LW'(MAX_VERTICES);
    end else begin
      n_eff = vc_ext;
    end
    n_m1     = n_eff - LW'(1);
    last_idx = n_m1[IW-1:0];
  end

  // Edge end vertex, wrapping to the first
  assign next_idx = (edge_idx == last_idx) ? '0 : edge_idx + IW'(1);
  assign query_go = (state == S_IDLE) && in_valid && (req_type == REQ_QUERY);
  assign res_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (query_go) state_next = S_RD_FIRST;
      S_RD_FIRST: state_next = S_LD_FIRST;
      S_LD_FIRST: state_next = S_RD_NEXT;
      S_RD_NEXT:  state_next = S_SETUP;
      S_SETUP:    state_next = S_MAC;
      S_MAC:      if (step == MAC_LAST_STEP) state_next = S_ADV;
      S_ADV:      state_next = (edge_idx == last_idx) ? S_FIN : S_RD_NEXT;
      S_FIN:      if (res_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs of the state
  always_comb begin
    in_stall        = (state != S_IDLE);
    ctrl            = '0;
    ctrl.take_point = query_go;
    rd_addr         = next_idx;
    mac_ctrl        = '{opa: OPA_AX, opb: OPB_BX, act: ACT_NONE};
    case (state)
      S_RD_FIRST: begin
        ctrl.mem_rd = 1'b1;
        rd_addr     = '0;
      end
      S_LD_FIRST: ctrl.take_first = 1'b1;
      S_RD_NEXT:  ctrl.mem_rd = 1'b1;
      S_SETUP:    ctrl.take_edge = 1'b1;
      S_MAC:      mac_ctrl = mac_step(step);
      S_ADV:      ctrl.advance = 1'b1;
      default: ;
    endcase
  end

  // Hold the result until taken; a new one lands when the register frees up
  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (state == S_FIN && res_free) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      edge_idx  <= '0;
      step      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      // Advance the edge walk
      if (query_go) begin
        edge_idx <= '0;
      end else if (state == S_ADV && edge_idx != last_idx) begin
        edge_idx <= edge_idx + IW'(1);
      end
      // Advance the multiplier schedule
      if (state == S_SETUP) begin
        step <= '0;
      end else if (state == S_MAC) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  // Track whether every edge so far gave a negative value
  always_ff @(posedge clk) begin
    if (query_go) begin
      all_neg <= 1'b1;
    end else if (mac_stat.done && !mac_stat.neg) begin
      all_neg <= 1'b0;
    end
    if (state == S_FIN && res_free) begin
      inside_res <= all_neg;
    end
  end

endmodule

[sv/point_in_convex_polygon.sv]
// ----------------------------------------------------------------------------
// point_in_convex_polygon
// Tests whether a 3D point lies strictly inside a convex polygon.
// ----------------------------------------------------------------------------
// A load item (req_type 0) writes one vertex into the table and is taken
// with no result. A query item (req_type 1) shifts the point by the plane
// origin, walks the edges of the polygon (one per vertex, vertex_count
// clamped to 3..MAX_VERTICES) and returns one inside_res: 1 when the triple product
// of every edge is strictly negative, 0 otherwise, points on an edge included.
// A query stalls the input from acceptance until its result is written,
// also while the previous result is still held at the output; per edge the
// vertex table is read and the edge set up, then one 27x27 multiplier is
// used twelve times in a fourteen-step schedule and the walk advances. The
// vertex table has no reset: every slot a query reads must have been loaded.
// Configuration must be written only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module point_in_convex_polygon
  import pcp_pkg::*;
#(
  parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // Input items
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic [VIDX_W-1:0]        vertex_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  // Result items
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     inside_res
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int XW = (IW > VIDX_W) ? IW : VIDX_W;

  // Configuration registers
  logic [CNT_W-1:0]          vertex_count;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] origin_z;
  logic signed [NORM_W-1:0]  normal_x;
  logic signed [NORM_W-1:0]  normal_y;
  logic signed [NORM_W-1:0]  normal_z;

  // Edge datapath
  logic signed [DIFF_W-1:0]  px, py, pz;
  logic signed [COORD_W-1:0] prev_x, prev_y, prev_z;
  logic signed [COORD_W-1:0] cur_x, cur_y, cur_z;
  logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;
  logic signed [DIFF_W-1:0]  ax, ay, az;
  logic signed [B_W-1:0]     bx, by, bz;

  logic              mem_we;
  logic [XW-1:0]     vidx_ext;
  logic [IW-1:0]     wr_addr;
  logic [IW-1:0]     rd_addr;
  logic [VTX_W-1:0]  rd_data;
  seq_ctrl_t         ctrl;
  mac_ctrl_t         mac_ctrl;
  mac_stat_t         mac_stat;

  // Write configuration registers; unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= RST_VERTEX_COUNT;
      origin_x     <= '0;
      origin_y     <= '0;
      origin_z     <= '0;
      normal_x     <= '0;
      normal_y     <= '0;
      normal_z     <= RST_NORMAL_Z;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VERTEX_COUNT: vertex_count <= cfg_data[CNT_W-1:0];
        REG_ORIGIN_X:     origin_x     <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y:     origin_y     <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Z:     origin_z     <= cfg_data[COORD_W-1:0];
        REG_NORMAL_X:     normal_x     <= cfg_data[NORM_W-1:0];
        REG_NORMAL_Y:     normal_y     <= cfg_data[NORM_W-1:0];
        REG_NORMAL_Z:     normal_z     <= cfg_data[NORM_W-1:0];
        default: ;
      endcase
    end
  end

  // Load items write the table; slots past the table are dropped
  assign vidx_ext = XW'(vertex_index);
  assign wr_addr  = vidx_ext[IW-1:0];
  assign mem_we   = in_valid && !in_stall && (req_type == REQ_LOAD) &&
                    (32'(vertex_index) < MAX_VERTICES);

  pcp_vmem #(
    .DEPTH(MAX_VERTICES)
  ) u_vmem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_addr),
    .wr_data ({coord_z, coord_y, coord_x}),
    .rd_en   (ctrl.mem_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_x = rd_data[COORD_W-1:0];
  assign rd_y = rd_data[2*COORD_W-1:COORD_W];
  assign rd_z = rd_data[3*COORD_W-1:2*COORD_W];

  // Capture the shifted point, the edge vertices and the edge vectors
  always_ff @(posedge clk) begin
    if (ctrl.take_point) begin
      px <= DIFF_W'(coord_x) - DIFF_W'(origin_x);
      py <= DIFF_W'(coord_y) - DIFF_W'(origin_y);
      pz <= DIFF_W'(coord_z) - DIFF_W'(origin_z);
    end
    if (ctrl.take_first) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
      prev_z <= rd_z;
    end else if (ctrl.advance) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
      prev_z <= cur_z;
    end
    if (ctrl.take_edge) begin
      cur_x <= rd_x;
      cur_y <= rd_y;
      cur_z <= rd_z;
      ax    <= DIFF_W'(rd_x) - DIFF_W'(prev_x);
      ay    <= DIFF_W'(rd_y) - DIFF_W'(prev_y);
      az    <= DIFF_W'(rd_z) - DIFF_W'(prev_z);
      bx    <= B_W'(px) - B_W'(prev_x);
      by    <= B_W'(py) - B_W'(prev_y);
      bz    <= B_W'(pz) - B_W'(prev_z);
    end
  end

  pcp_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .ax   (ax),
    .ay   (ay),
    .az   (az),
    .bx   (bx),
    .by   (by),
    .bz   (bz),
    .nx   (normal_x),
    .ny   (normal_y),
    .nz   (normal_z),
    .stat (mac_stat)
  );

  pcp_seq #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .req_type     (req_type),
    .out_stall    (out_stall),
    .vertex_count (vertex_count),
    .mac_stat     (mac_stat),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .inside_res   (inside_res),
    .rd_addr      (rd_addr),
    .ctrl         (ctrl),
    .mac_ctrl     (mac_ctrl)
  );

endmodule

[sv/pcp_checker.sv]
// ----------------------------------------------------------------------------
// pcp_checker
// Port-level checks on item flow, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_in_convex_polygon_assert.svh"

module pcp_assert_checker
  import pcp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic req_type,
  input logic out_valid,
  input logic out_stall,
  input logic inside_res
);

  logic in_load;
  logic in_query;

  // Accepted input items by kind
  assign in_load  = in_valid && !in_stall && (req_type == REQ_LOAD);
  assign in_query = in_valid && !in_stall && (req_type == REQ_QUERY);

  // A load item from an empty output never produces a result
  `PCP_ASSERT_NEXT(a_load_no_result, clk, rst, in_load && !out_valid, !out_valid, "load gave result")

  // An accepted query occupies the block
  `PCP_ASSERT_NEXT(a_query_busy, clk, rst, in_query, in_stall, "query accepted, input not stalled")

  // A new result only appears at the end of a query
  `PCP_ASSERT_SAME(a_result_from_query, clk, rst, $rose(out_valid), $past(in_stall), "stray result")

  // A stalled result holds
  `PCP_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && out_stall, out_valid && $stable(inside_res), "stalled result changed")

endmodule

bind point_in_convex_polygon pcp_assert_checker u_pcp_assert_checker (.*);
